FILE: rtl/hbp_pkg.sv
// hbp_pkg: shared constants, codes and types of the huffman bit packer
// depends on nothing; used by the interfaces and imported by every module of the block
package hbp_pkg;

   // table geometry
   localparam int SYMBOLS      = 256;
   localparam int MAX_CODE_LEN = 32;
   localparam int ADDR_W       = $clog2(SYMBOLS);

   // field widths
   localparam int MODE_W   = 2;
   localparam int SYMBOL_W = 8;
   localparam int LEN_W    = 6;
   localparam int CODE_W   = 32;
   localparam int BYTE_W   = 8;

   // stored length never exceeds the code word width
   localparam int EFF_MAX_LEN = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

   // merged pending bits plus one code word
   localparam int ACC_W   = CODE_W + BYTE_W;
   localparam int TOTAL_W = $clog2(ACC_W + 1);
   localparam int CNT_W   = $clog2(BYTE_W);

   // request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD   = 2'd0,
      MODE_ENCODE = 2'd1,
      MODE_FLUSH  = 2'd2
   } hbp_mode_type;

   // result status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_MISS = 1'b1;

   // one lookup result handed from the table stage to the packer
   typedef struct packed {
      logic              flush;
      logic              hit;
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } hbp_lookup_type;

endpackage

FILE: rtl/hbp_req_if.sv
// hbp_req_if: request channel of the huffman bit packer, valid/ready with payload
// depends on hbp_pkg for field widths
interface hbp_req_if;
   logic                          valid;
   logic                          ready;
   logic [hbp_pkg::MODE_W-1:0]    mode;
   logic [hbp_pkg::SYMBOL_W-1:0]  symbol;
   logic [hbp_pkg::LEN_W-1:0]     code_length;
   logic [hbp_pkg::CODE_W-1:0]    code_bits;

   modport source (output valid, mode, symbol, code_length, code_bits, input ready);
   modport sink   (input valid, mode, symbol, code_length, code_bits, output ready);
endinterface

FILE: rtl/hbp_rsp_if.sv
// hbp_rsp_if: result channel of the huffman bit packer, valid/ready with payload
// depends on hbp_pkg for field widths
interface hbp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hbp_pkg::BYTE_W-1:0]  out_byte;
   logic                        status;
   logic                        last;

   modport source (output valid, out_byte, status, last, input ready);
   modport sink   (input valid, out_byte, status, last, output ready);
endinterface

FILE: rtl/huffman_bit_packer_core.sv
// Huffman bit packer core. A load request writes the code word and length of one
// symbol into a 256-entry table; an encode request looks the symbol up and appends
// its code bits, bit 0 first, into a pending byte filled from bit 0 upward, sending
// each byte as it fills; a flush sends any partial byte zero padded and marked last.
// Encoding a symbol that was never loaded gives one result with status 1. An encode
// completes at most 4 bytes and holds the packer until it has sent them all, since
// the result channel moves one byte per transfer. The first byte of an encode passes
// through the registered table read, then the packing into the result register.
// Valid marks live in flip-flops cleared by reset, so the block accepts requests
// right after reset.
// depends on hbp_pkg, hbp_req_if, hbp_rsp_if, hbp_code_mem and hbp_packer
module huffman_bit_packer_core (
   input  logic      clock,
   input  logic      reset,
   hbp_req_if.sink   req_ch,
   hbp_rsp_if.source rsp_ch
);
   import hbp_pkg::*;

   logic           req_fire;
   logic           lk_valid;
   logic           lk_take;
   hbp_lookup_type lk;

   // the lookup stage frees whenever the packer takes its entry
   assign req_ch.ready = !lk_valid || lk_take;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // table and lookup stage
   hbp_code_mem u_code_mem (
      .clock           (clock),
      .reset           (reset),
      .req_fire        (req_fire),
      .req_mode        (req_ch.mode),
      .req_symbol      (req_ch.symbol),
      .req_code_length (req_ch.code_length),
      .req_code_bits   (req_ch.code_bits),
      .lk_valid        (lk_valid),
      .lk              (lk),
      .lk_take         (lk_take)
   );

   // byte packing and result register
   hbp_packer u_packer (
      .clock        (clock),
      .reset        (reset),
      .lk_valid     (lk_valid),
      .lk           (lk),
      .lk_take      (lk_take),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_out_byte (rsp_ch.out_byte),
      .rsp_status   (rsp_ch.status),
      .rsp_last     (rsp_ch.last)
   );

endmodule

FILE: rtl/hbp_code_mem.sv
// hbp_code_mem: code table memory, valid bits and the registered lookup stage
// depends on hbp_pkg
module hbp_code_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_fire,
   input  logic [hbp_pkg::MODE_W-1:0]    req_mode,
   input  logic [hbp_pkg::SYMBOL_W-1:0]  req_symbol,
   input  logic [hbp_pkg::LEN_W-1:0]     req_code_length,
   input  logic [hbp_pkg::CODE_W-1:0]    req_code_bits,
   output logic                          lk_valid,
   output hbp_pkg::hbp_lookup_type       lk,
   input  logic                          lk_take
);
   import hbp_pkg::*;

   localparam int ENTRY_W = LEN_W + CODE_W;

   logic [ENTRY_W-1:0] mem [SYMBOLS];
   logic [SYMBOLS-1:0] entry_valid_ff;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               lk_valid_ff;
   logic               flush_ff;
   logic               hit_ff;

   logic [ADDR_W-1:0]  idx;
   logic               sym_ok;
   logic               do_write;
   logic               do_lookup;
   logic [LEN_W-1:0]   len_sat;

   // decode of the incoming transfer
   always_comb begin
      idx       = req_symbol[ADDR_W-1:0];
      sym_ok    = ({1'b0, req_symbol} < (SYMBOL_W+1)'(SYMBOLS));
      do_write  = req_fire && (req_mode == MODE_LOAD) && sym_ok;
      do_lookup = req_fire && ((req_mode == MODE_ENCODE) || (req_mode == MODE_FLUSH));
      if (req_code_length > LEN_W'(EFF_MAX_LEN)) begin
         len_sat = LEN_W'(EFF_MAX_LEN);
      end else begin
         len_sat = req_code_length;
      end
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[idx] <= {len_sat, req_code_bits};
      end
      if (do_lookup) begin
         rd_data_ff <= mem[idx];
      end
   end

   // valid marks, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (do_write) begin
         entry_valid_ff[idx] <= 1'b1;
      end
   end

   // lookup stage occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         lk_valid_ff <= 1'b0;
      end else if (do_lookup) begin
         lk_valid_ff <= 1'b1;
      end else if (lk_take) begin
         lk_valid_ff <= 1'b0;
      end
   end

   // lookup stage payload
   always_ff @(posedge clock) begin
      if (do_lookup) begin
         flush_ff <= (req_mode == MODE_FLUSH);
         hit_ff   <= sym_ok && entry_valid_ff[idx];
      end
   end

   // stored entry is {len, code}, matching the tail of the lookup struct
   assign lk_valid = lk_valid_ff;
   assign lk       = {flush_ff, hit_ff, rd_data_ff};

endmodule

FILE: rtl/hbp_packer.sv
// hbp_packer: merges code words into the pending byte and drives the result register
// depends on hbp_pkg
module hbp_packer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        lk_valid,
   input  hbp_pkg::hbp_lookup_type     lk,
   output logic                        lk_take,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [hbp_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_status,
   output logic                        rsp_last
);
   import hbp_pkg::*;

   localparam int EMIT_W = 2;

   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [EMIT_W-1:0]  emit_ff, emit_in;
   logic               busy_ff, busy_in;
   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               out_status_ff, out_status_in;
   logic               out_last_ff, out_last_in;

   logic               out_free;
   logic [CODE_W-1:0]  mask;
   logic [ACC_W-1:0]   merged;
   logic [TOTAL_W-1:0] total;
   logic [TOTAL_W-4:0] nbytes;

   // merge of the pending bits with the looked-up code word
   always_comb begin
      mask   = CODE_W'(((CODE_W+1)'(1) << lk.len) - (CODE_W+1)'(1));
      merged = (ACC_W'(lk.code & mask) << cnt_ff) | ACC_W'(acc_ff[BYTE_W-1:0]);
      total  = TOTAL_W'(cnt_ff) + TOTAL_W'(lk.len);
      nbytes = total[TOTAL_W-1:3];
   end

   assign out_free = !out_valid_ff || rsp_ready;
   assign lk_take  = lk_valid && !busy_ff && out_free;

   // next state: drain full bytes, else take the next lookup
   always_comb begin
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      emit_in       = emit_ff;
      busy_in       = busy_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_byte_in   = out_byte_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;

      if (busy_ff && out_free) begin
         out_valid_in  = 1'b1;
         out_byte_in   = acc_ff[BYTE_W-1:0];
         out_status_in = STATUS_OK;
         out_last_in   = 1'b0;
         acc_in        = acc_ff >> BYTE_W;
         emit_in       = emit_ff - EMIT_W'(1);
         busy_in       = (emit_ff != EMIT_W'(1));
      end else if (lk_take) begin
         if (lk.flush) begin
            // flush sends the partial byte, zero padded
            if (cnt_ff != '0) begin
               out_valid_in  = 1'b1;
               out_byte_in   = acc_ff[BYTE_W-1:0];
               out_status_in = STATUS_OK;
               out_last_in   = 1'b1;
               acc_in        = '0;
               cnt_in        = '0;
            end
         end else if (!lk.hit) begin
            // unknown symbol gives one error result
            out_valid_in  = 1'b1;
            out_byte_in   = '0;
            out_status_in = STATUS_MISS;
            out_last_in   = 1'b0;
         end else begin
            cnt_in = total[CNT_W-1:0];
            if (nbytes != '0) begin
               // first full byte leaves in the same cycle
               out_valid_in  = 1'b1;
               out_byte_in   = merged[BYTE_W-1:0];
               out_status_in = STATUS_OK;
               out_last_in   = 1'b0;
               acc_in        = merged >> BYTE_W;
               emit_in       = EMIT_W'(nbytes - 1'b1);
               busy_in       = (nbytes != (TOTAL_W-3)'(1));
            end else begin
               acc_in = merged;
            end
         end
      end
   end

   // control and pending state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         emit_ff      <= '0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         emit_ff      <= emit_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_last     = out_last_ff;

endmodule
